// ===== sv/tpbd_pkg.sv =====
`timescale 1ns / 1ps
package tpbd_pkg;

  // Framing constants
  localparam logic [31:0] SYNC_WORD   = 32'h0101_3c5a;
  localparam logic [11:0] DELAY_RESET = 12'd555;

  // Level codes
  localparam logic [1:0] LEVEL_ZERO = 2'd0;

  // Byte kinds on the result word
  localparam logic [1:0] KIND_TYPE  = 2'd0;
  localparam logic [1:0] KIND_LEN   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_TRAIL = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_LEVEL = 1'b1;

  typedef struct packed {
    logic [1:0]  pulse_level;
    logic [15:0] pulse_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0] byte_kind;
    logic [7:0] byte_value;
    logic [7:0] running_sum;
    logic       block_end;
  } out_word_t;

  // Recovered bit passed from the bit recovery to the framer
  typedef struct packed {
    logic valid;
    logic value;
  } bit_t;

endpackage

// ===== sv/tpbd_bitrec.sv =====
`timescale 1ns / 1ps
module tpbd_bitrec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tpbd_pkg::in_word_t pulse_i,
  input  logic [11:0]       sample_delay_i,
  input  logic              level_we_i,
  input  logic [1:0]        level_wdata_i,
  output tpbd_pkg::bit_t    bit_o
);
  import tpbd_pkg::*;

  logic [1:0]  last_level_q, last_level_d;
  logic        measuring_q, measuring_d;
  logic [16:0] elapsed_q, elapsed_d;

  logic        start;
  logic        active;
  logic [16:0] base;
  logic [16:0] sum;
  logic        done;

  // Find the transition pulse and accumulate time up to the sample point
  always_comb begin
    start  = !measuring_q && (pulse_i.pulse_level != last_level_q) &&
             (pulse_i.pulse_level != LEVEL_ZERO);
    active = measuring_q || start;
    base   = measuring_q ? elapsed_q : 17'd0;
    sum    = base + {1'b0, pulse_i.pulse_length};
    done   = active && (sum >= {5'd0, sample_delay_i});
    bit_o.valid = done;
    bit_o.value = (pulse_i.pulse_level == last_level_q);
  end

  // Next measurement state
  always_comb begin
    last_level_d = last_level_q;
    measuring_d  = measuring_q;
    elapsed_d    = elapsed_q;
    if (en_i) begin
      if (done) begin
        last_level_d = pulse_i.pulse_level;
        measuring_d  = 1'b0;
        elapsed_d    = 17'd0;
      end else if (active) begin
        measuring_d = 1'b1;
        elapsed_d   = sum;
      end
    end
    if (level_we_i) begin
      last_level_d = level_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= LEVEL_ZERO;
      measuring_q  <= 1'b0;
      elapsed_q    <= 17'd0;
    end else begin
      last_level_q <= last_level_d;
      measuring_q  <= measuring_d;
      elapsed_q    <= elapsed_d;
    end
  end

`ifndef SYNTH
  // Time is only carried while a transition is being measured
  a_idle_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !measuring_q |-> elapsed_q == 17'd0)
    else $error("elapsed time held while not measuring");
`endif

endmodule

// ===== sv/tpbd_framer.sv =====
`timescale 1ns / 1ps
module tpbd_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tpbd_pkg::bit_t      bit_i,
  output logic                res_valid_o,
  output tpbd_pkg::out_word_t res_o
);
  import tpbd_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] sync_q, sync_d;
  logic [2:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  csum_q, csum_d;

  logic [31:0] sync_shifted;
  logic [7:0]  byte_full;
  logic [2:0]  idx_next;
  logic [7:0]  csum_add;
  logic [7:0]  len_left;
  logic [7:0]  left_dec;

  always_comb begin
    sync_shifted = {sync_q[30:0], bit_i.value};
    byte_full    = {byte_q[6:0], bit_i.value};
    idx_next     = bit_idx_q + 3'd1;
    csum_add     = csum_q + byte_full;
    len_left     = byte_full - 8'd2;
    left_dec     = left_q - 8'd1;
  end

  // Hunt for sync, then assemble bytes and walk through the block
  always_comb begin
    phase_d     = phase_q;
    sync_d      = sync_q;
    bit_idx_d   = bit_idx_q;
    byte_d      = byte_q;
    left_d      = left_q;
    csum_d      = csum_q;
    res_valid_o = 1'b0;
    res_o       = '{byte_kind: KIND_TYPE, byte_value: byte_full,
                    running_sum: 8'd0, block_end: 1'b0};
    if (bit_i.valid) begin
      if (phase_q == PH_HUNT || phase_q > PH_TRAIL) begin
        sync_d = sync_shifted;
        if (sync_shifted == SYNC_WORD) begin
          phase_d   = PH_TYPE;
          bit_idx_d = 3'd0;
          byte_d    = 8'd0;
          csum_d    = 8'd0;
        end
      end else begin
        byte_d    = byte_full;
        bit_idx_d = idx_next;
        if (idx_next == 3'd0) begin
          byte_d      = 8'd0;
          res_valid_o = 1'b1;
          unique case (phase_q)
            PH_TYPE: begin
              res_o.byte_kind = KIND_TYPE;
              phase_d         = PH_LEN;
            end
            PH_LEN: begin
              res_o.byte_kind = KIND_LEN;
              csum_d          = 8'd0;
              left_d          = len_left;
              phase_d         = (len_left != 8'd0) ? PH_DATA : PH_TRAIL;
            end
            PH_DATA: begin
              res_o.byte_kind   = KIND_DATA;
              res_o.running_sum = csum_add;
              csum_d            = csum_add;
              left_d            = left_dec;
              if (left_dec == 8'd0) begin
                phase_d = PH_TRAIL;
              end
            end
            default: begin
              res_o.byte_kind   = KIND_TRAIL;
              res_o.running_sum = csum_add;
              res_o.block_end   = 1'b1;
              phase_d           = PH_HUNT;
              sync_d            = 32'd0;
              csum_d            = 8'd0;
              bit_idx_d         = 3'd0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      sync_q    <= 32'd0;
      bit_idx_q <= 3'd0;
      byte_q    <= 8'd0;
      left_q    <= 8'd0;
      csum_q    <= 8'd0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      sync_q    <= sync_d;
      bit_idx_q <= bit_idx_d;
      byte_q    <= byte_d;
      left_q    <= left_d;
      csum_q    <= csum_d;
    end
  end

`ifndef SYNTH
  // A closing trailer always sends the framer back to hunting
  a_trail_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_valid_o && res_o.block_end |=> phase_q == PH_HUNT && sync_q == 32'd0)
    else $error("framer did not return to hunt after trailer");

  // Byte assembly only runs while inside a block
  a_hunt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> bit_idx_q == 3'd0)
    else $error("bit index moved while hunting");
`endif

endmodule

// ===== sv/tape_pulse_block_deframer.sv =====
`timescale 1ns / 1ps
// Path: a pulse word is held in the input register, and its result word in the output register.
// Throughput: one pulse word per cycle; the input register and the state update of the
// bit recovery and framer take a new word every cycle unless the output register is held.
// Reset: rst_ni clears all control state asynchronously; sample_delay returns to 555,
// initial_level and the last sampled level to zero, and the framer to sync hunting.
module tape_pulse_block_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpbd_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpbd_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tpbd_pkg::*;

  logic        in_valid_q;
  in_word_t    in_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic [11:0] delay_q;
  logic [1:0]  init_level_q;

  logic        cfg_we;
  logic        level_we;
  logic        fire;
  bit_t        rec_bit;
  logic        res_valid;
  out_word_t   res_word;

  // Configuration port
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign level_we = cfg_we && (paddr[2] == REG_LEVEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q      <= DELAY_RESET;
      init_level_q <= LEVEL_ZERO;
    end else if (cfg_we) begin
      if (paddr[2] == REG_DELAY) begin
        delay_q <= pwdata[11:0];
      end else begin
        init_level_q <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DELAY) begin
      prdata = {20'd0, delay_q};
    end else begin
      prdata = {30'd0, init_level_q};
    end
  end

  // Process the held word when its result has somewhere to go
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i || !res_valid);
  assign in_ready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_data_i;
    end
  end

  tpbd_bitrec u_bitrec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (fire),
    .pulse_i        (in_word_q),
    .sample_delay_i (delay_q),
    .level_we_i     (level_we),
    .level_wdata_i  (pwdata[1:0]),
    .bit_o          (rec_bit)
  );

  tpbd_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (fire),
    .bit_i       (rec_bit),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

`ifndef SYNTH
  // Only the trailer closes a block
  a_end_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.block_end |-> out_word_q.byte_kind == KIND_TRAIL)
    else $error("block end on a byte that is not the trailer");

  // Header bytes carry no running sum
  a_head_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_word_q.byte_kind == KIND_TYPE || out_word_q.byte_kind == KIND_LEN)
    |-> out_word_q.running_sum == 8'd0)
    else $error("nonzero sum on a header byte");

  // A held input word is never dropped while it waits
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_word_q))
    else $error("waiting input word lost");
`endif

endmodule
